/* src/gradient_grain_background_generator_core_assert.svh */
// assertion macros for the background generator core
`ifndef GRADIENT_GRAIN_BACKGROUND_GENERATOR_CORE_ASSERT_SVH
`define GRADIENT_GRAIN_BACKGROUND_GENERATOR_CORE_ASSERT_SVH

`ifndef SYNTH
`define GGBG_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ggbg assertion failed");
`define GGBG_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ggbg assertion failed");
`else
`define GGBG_ASSERT_IMP(lbl, pre, post)
`define GGBG_ASSERT_NXT(lbl, pre, post)
`endif

`endif

/* src/ggbg_pkg.sv */
// shared types, constants and helpers of the background generator
package ggbg_pkg;

  localparam logic [31:0] SEED_INIT = 32'h1337BEEF;

  // configuration register indexes
  localparam logic [1:0] REG_THEME  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_PHASE  = 2'd3;

  // themes
  localparam logic [1:0] THEME_CORNER  = 2'd0;
  localparam logic [1:0] THEME_NAVY    = 2'd1;
  localparam logic [1:0] THEME_VIOLET  = 2'd2;
  localparam logic [1:0] THEME_CRIMSON = 2'd3;

  // one classified pixel request between front and back
  typedef struct packed {
    logic        frame_start;
    logic        row_start;
    logic [12:0] row;
    logic        row_end;
    logic        frame_end;
  } q_item_t;

  // clamp a size register to 1..mx
  function automatic logic [12:0] eff_dim(logic [12:0] d, logic [13:0] mx);
    logic [12:0] r;
    r = d;
    if (d == 13'd0) r = 13'd1;
    if ({1'b0, d} > mx) r = mx[12:0];
    return r;
  endfunction

endpackage

/* src/ggbg_div.sv */
// iterative unsigned divider, one quotient bit per cycle
module ggbg_div import ggbg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [12:0] den,
  output logic        done,
  output logic [31:0] quo,
  output logic [12:0] rem
);

  localparam int NBITS = 32;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] quo_r;
  logic [12:0] rem_r;
  logic [12:0] den_r;
  logic [13:0] sh;
  logic [13:0] diff;

  assign sh   = {rem_r, quo_r[NBITS-1]};
  assign diff = sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        if (sh >= {1'b0, den_r}) begin
          rem_r <= diff[12:0];
          quo_r <= {quo_r[NBITS-2:0], 1'b1};
        end else begin
          rem_r <= sh[12:0];
          quo_r <= {quo_r[NBITS-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(NBITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

/* src/ggbg_front.sv */
// raster position tracking and classification of each request
module ggbg_front import ggbg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic        start_frame,
  input  logic [12:0] w,
  input  logic [12:0] h,
  output q_item_t     item
);

  logic [12:0] col_r, row_r;
  logic [12:0] col_c, row_c;
  logic [12:0] col_nxt, row_nxt;
  logic        re, fe;

  always_comb begin
    col_c = start_frame ? 13'd0 : col_r;
    row_c = start_frame ? 13'd0 : row_r;
    if (col_c >= w) col_c = w - 13'd1;
    if (row_c >= h) row_c = h - 13'd1;
    re = (col_c == w - 13'd1);
    fe = re && (row_c == h - 13'd1);
    if (re) begin
      col_nxt = 13'd0;
      row_nxt = fe ? 13'd0 : row_c + 13'd1;
    end else begin
      col_nxt = col_c + 13'd1;
      row_nxt = row_c;
    end
    item.frame_start = (col_c == 13'd0) && (row_c == 13'd0);
    item.row_start   = (col_c == 13'd0);
    item.row         = row_c;
    item.row_end     = re;
    item.frame_end   = fe;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* src/ggbg_queue.sv */
// two-entry queue of classified requests
module ggbg_queue import ggbg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr,
  input  q_item_t wr_item,
  input  logic    rd,
  output q_item_t rd_item,
  output logic    full,
  output logic    nempty
);

  q_item_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign nempty  = (cnt_r != 2'd0);
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      case ({wr, rd})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* src/ggbg_back.sv */
// sequenced frame, row and pixel work on one request at a time
module ggbg_back import ggbg_pkg::*; #(
  parameter int GRAIN_STRIDE = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  q_item_t     q_item,
  input  logic        q_nempty,
  output logic        q_pop,
  input  logic [1:0]  theme,
  input  logic [31:0] phase,
  input  logic [12:0] w,
  input  logic [12:0] h,
  input  logic        pop,
  output logic        out_valid,
  output logic [23:0] out_color,
  output logic        out_row_end,
  output logic        out_frame_end
);

  // micro-op numbering
  localparam logic [4:0] OP_MOD  = 5'd0;
  localparam logic [4:0] OP_TRI  = 5'd3;
  localparam logic [4:0] OP_EDGE = 5'd6;
  localparam logic [4:0] OP_STEP = 5'd12;
  localparam logic [4:0] OP_VERT = 5'd15;
  localparam logic [4:0] OP_LAST = 5'd23;

  typedef enum logic [1:0] {B_IDLE, B_OPS, B_PIX} bstate_t;

  function automatic logic [7:0] sat8(logic signed [9:0] v);
    if (v < 0) return 8'd0;
    if (v > 10'sd255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic logic [31:0] xs32(logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  function automatic logic [7:0] tri_per(logic [1:0] k);
    case (k)
      2'd0:    return 8'd120;
      2'd1:    return 8'd140;
      default: return 8'd160;
    endcase
  endfunction

  function automatic logic [4:0] tri_amp(logic [1:0] k);
    case (k)
      2'd0:    return 5'd10;
      2'd1:    return 5'd12;
      default: return 5'd8;
    endcase
  endfunction

  function automatic logic [5:0] vert_k(logic [3:0] v);
    case (v)
      4'd0:    return 6'd15;
      4'd1:    return 6'd35;
      4'd2:    return 6'd55;
      4'd3:    return 6'd10;
      4'd4:    return 6'd45;
      4'd5:    return 6'd30;
      4'd6:    return 6'd30;
      4'd7:    return 6'd10;
      default: return 6'd25;
    endcase
  endfunction

  function automatic logic [7:0] plus_tri(logic [7:0] base, logic signed [5:0] s);
    return sat8(signed'({2'b00, base}) + 10'(s));
  endfunction

  bstate_t            state_r;
  logic [4:0]         op_r;
  logic               launched_r;
  q_item_t            cur_r;
  logic [31:0]        seed_r;
  logic [1:0]         gcnt_r;
  logic [12:0]        ycache_r, hcache_r;
  logic [7:0]         p_r    [3];
  logic signed [5:0]  tri_r  [3];
  logic signed [9:0]  edge_r [6];
  logic [31:0]        acc_r  [3];
  logic [31:0]        step_r [3];
  logic [7:0]         vq_r   [9];
  logic               out_valid_r;
  logic [23:0]        out_color_r;
  logic               out_re_r, out_fe_r;

  logic [7:0]         corner [12];
  logic               div_start, div_done, div_neg;
  logic [31:0]        div_num, div_quo, qs;
  logic [12:0]        div_den, div_rem;
  logic [1:0]         kf, ce;
  logic               side;
  logic [2:0]         je;
  logic [3:0]         vi;
  logic [7:0]         half, pd;
  logic               up;
  logic signed [9:0]  dif;
  logic signed [23:0] prod;
  logic [12:0]        dw, dh;
  logic [7:0]         tv, bv;
  logic               out_free;
  logic [7:0]         cr, cg, cb;
  logic [31:0]        seed_nxt;
  logic signed [9:0]  noise;
  logic [2:0]         gcnt_inc;
  logic [1:0]         gcnt_nxt;

  // corner colours, some of them offset by the triangle values of the current frame
  always_comb begin
    corner[0]  = plus_tri(8'h1E, tri_r[0]);
    corner[1]  = 8'h1E;
    corner[2]  = plus_tri(8'h2E, tri_r[1]);
    corner[3]  = 8'h1A;
    corner[4]  = plus_tri(8'h18, tri_r[2]);
    corner[5]  = plus_tri(8'h28, tri_r[0]);
    corner[6]  = 8'h11;
    corner[7]  = plus_tri(8'h11, tri_r[1]);
    corner[8]  = 8'h1B;
    corner[9]  = plus_tri(8'h18, tri_r[1]);
    corner[10] = 8'h18;
    corner[11] = plus_tri(8'h25, tri_r[2]);
  end

  assign dw = (w > 13'd1) ? w - 13'd1 : 13'd1;
  assign dh = (h > 13'd1) ? h - 13'd1 : 13'd1;

  // operand selection for the current micro-op
  always_comb begin
    div_num = '0;
    div_den = 13'd1;
    div_neg = 1'b0;
    kf   = '0;
    je   = '0;
    ce   = '0;
    side = 1'b0;
    vi   = '0;
    half = '0;
    pd   = '0;
    up   = 1'b0;
    tv   = '0;
    bv   = '0;
    dif  = '0;
    prod = '0;
    unique case (op_r) inside
      [OP_MOD:OP_TRI-5'd1]: begin
        kf      = op_r[1:0];
        div_num = phase + 32'(8'd40 * {6'd0, kf});
        div_den = 13'(tri_per(kf));
      end
      [OP_TRI:OP_EDGE-5'd1]: begin
        kf      = 2'(op_r - OP_TRI);
        half    = tri_per(kf) >> 1;
        up      = p_r[kf] >= half;
        pd      = up ? p_r[kf] - half : p_r[kf];
        div_num = 32'({tri_amp(kf), 1'b0} * pd);
        div_den = 13'(half);
      end
      [OP_EDGE:OP_STEP-5'd1]: begin
        je      = 3'(op_r - OP_EDGE);
        side    = (je >= 3'd3);
        ce      = side ? 2'(je - 3'd3) : je[1:0];
        tv      = corner[side ? 4'd3 + 4'(ce) : 4'(ce)];
        bv      = corner[side ? 4'd9 + 4'(ce) : 4'd6 + 4'(ce)];
        dif     = signed'({2'b00, bv}) - signed'({2'b00, tv});
        prod    = dif * signed'({1'b0, cur_r.row});
        div_neg = prod[23];
        div_num = 32'(prod[23] ? -prod : prod);
        div_den = dh;
      end
      [OP_STEP:OP_VERT-5'd1]: begin
        ce      = 2'(op_r - OP_STEP);
        dif     = edge_r[3'd3 + 3'(ce)] - edge_r[3'(ce)];
        div_neg = dif[9];
        div_num = {6'd0, (dif[9] ? 10'(-dif) : dif), 16'd0};
        div_den = dw;
      end
      [OP_VERT:OP_LAST]: begin
        vi      = 4'(op_r - OP_VERT);
        div_num = 32'(cur_r.row * vert_k(vi));
        div_den = h;
      end
      default: begin
        div_num = '0;
      end
    endcase
  end

  assign qs        = div_neg ? -div_quo : div_quo;
  assign div_start = (state_r == B_OPS) && !launched_r;
  assign q_pop     = (state_r == B_IDLE) && q_nempty;
  assign out_free  = !out_valid_r || pop;

  // pixel colour and grain
  always_comb begin
    case (theme)
      THEME_NAVY: begin
        cr = 8'd10 + vq_r[0];
        cg = 8'd18 + vq_r[1];
        cb = 8'd38 + vq_r[2];
      end
      THEME_VIOLET: begin
        cr = 8'd24 + vq_r[3];
        cg = 8'd32 + vq_r[4];
        cb = 8'd40 + vq_r[5];
      end
      THEME_CRIMSON: begin
        cr = 8'd45 - vq_r[6];
        cg = 8'd20 + vq_r[7];
        cb = 8'd40 + vq_r[8];
      end
      default: begin
        cr = acc_r[0][23:16];
        cg = acc_r[1][23:16];
        cb = acc_r[2][23:16];
      end
    endcase
    seed_nxt = xs32(seed_r);
    noise    = signed'({7'd0, seed_nxt[2:0]}) - 10'sd3;
    gcnt_inc = {1'b0, gcnt_r} + 3'd1;
    gcnt_nxt = (gcnt_inc >= 3'(GRAIN_STRIDE)) ? 2'd0 : gcnt_inc[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      op_r        <= '0;
      launched_r  <= 1'b0;
      seed_r      <= SEED_INIT;
      gcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && out_valid_r) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (q_nempty) begin
            cur_r <= q_item;
            if (q_item.frame_start) begin
              seed_r  <= SEED_INIT;
              gcnt_r  <= '0;
              op_r    <= OP_MOD;
              state_r <= B_OPS;
            end else if (q_item.row_start) begin
              op_r    <= OP_EDGE;
              state_r <= B_OPS;
            end else if (q_item.row != ycache_r || h != hcache_r) begin
              op_r    <= OP_VERT;
              state_r <= B_OPS;
            end else begin
              state_r <= B_PIX;
            end
          end
        end
        B_OPS: begin
          if (!launched_r) begin
            launched_r <= 1'b1;
          end else if (div_done) begin
            launched_r <= 1'b0;
            unique case (op_r) inside
              [OP_MOD:OP_TRI-5'd1]:  p_r[kf] <= div_rem[7:0];
              [OP_TRI:OP_EDGE-5'd1]: tri_r[kf] <= up ?
                  signed'({1'b0, tri_amp(kf)}) - 6'(div_quo) :
                  6'(div_quo) - signed'({1'b0, tri_amp(kf)});
              [OP_EDGE:OP_STEP-5'd1]: edge_r[je] <= signed'({2'b00, tv}) + 10'(qs);
              [OP_STEP:OP_VERT-5'd1]: begin
                step_r[ce] <= qs;
                acc_r[ce]  <= {8'd0, edge_r[3'(ce)][7:0], 16'd0};
              end
              [OP_VERT:OP_LAST]: vq_r[vi] <= div_quo[7:0];
              default: launched_r <= 1'b0;
            endcase
            if (op_r == OP_LAST) begin
              ycache_r <= cur_r.row;
              hcache_r <= h;
              state_r  <= B_PIX;
            end else begin
              op_r <= op_r + 5'd1;
            end
          end
        end
        B_PIX: begin
          if (out_free) begin
            if (gcnt_r == 2'd0) begin
              seed_r      <= seed_nxt;
              out_color_r <= {sat8(signed'({2'b00, cr}) + noise),
                              sat8(signed'({2'b00, cg}) + noise),
                              sat8(signed'({2'b00, cb}) + noise)};
            end else begin
              out_color_r <= {cr, cg, cb};
            end
            gcnt_r      <= gcnt_nxt;
            acc_r[0]    <= acc_r[0] + step_r[0];
            acc_r[1]    <= acc_r[1] + step_r[1];
            acc_r[2]    <= acc_r[2] + step_r[2];
            out_re_r    <= cur_r.row_end;
            out_fe_r    <= cur_r.frame_end;
            out_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  ggbg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign out_valid     = out_valid_r;
  assign out_color     = out_color_r;
  assign out_row_end   = out_re_r;
  assign out_frame_end = out_fe_r;

endmodule

/* src/gradient_grain_background_generator_core.sv */
// top level of the gradient and grain background generator
// usage:
//  - input queue side: push with in_start_frame while full is low; each beat asks
//    for the next raster pixel (start_frame high restarts at pixel zero)
//  - result queue side: while empty is low the oldest pixel sits on out_pixel_color,
//    out_row_end and out_frame_end; pop takes the beat
//  - apb-style port: theme, frame_width, frame_height, phase at byte 0, 4, 8, 12;
//    write only while the block is idle, reads return the register values
//  - a two-entry queue parts the position tracker from the sequencer, so
//    requests are taken while the sequencer or the result register is busy
//  - an ordinary pixel passes the queue, the sequencer and the result register;
//    the shared divider sets the rest: a row start runs 18 divisions, a frame
//    start 24, a change of frame_height mid row 9 divisions
//  - inside a row the sequencer finishes one pixel before it takes the next one
//  - reset: position to pixel zero, noise seed reloaded, queues emptied;
//    no clearing pass is needed
//  - receiver stall: the finished pixel waits in the result register, the
//    sequencer holds, the input queue fills and then raises full
module gradient_grain_background_generator_core import ggbg_pkg::*; #(
  parameter int MAX_WIDTH    = 7680,
  parameter int MAX_HEIGHT   = 4320,
  parameter int GRAIN_STRIDE = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  // input beats
  input  logic        push,
  output logic        full,
  input  logic        in_start_frame,
  // result beats
  output logic        empty,
  input  logic        pop,
  output logic [23:0] out_pixel_color,
  output logic        out_row_end,
  output logic        out_frame_end,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "gradient_grain_background_generator_core_assert.svh"

  logic [1:0]  theme_r;
  logic [12:0] width_r, height_r;
  logic [31:0] phase_r;
  logic [12:0] w_eff, h_eff;
  logic        cfg_we;
  logic        in_acc;
  q_item_t     f_item, q_item;
  logic        q_full, q_nempty, q_pop;
  logic        out_valid;

  // register file, written in the access phase
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theme_r  <= THEME_CORNER;
      width_r  <= 13'd1280;
      height_r <= 13'd800;
      phase_r  <= '0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_THEME:  theme_r  <= pwdata[1:0];
        REG_WIDTH:  width_r  <= pwdata[12:0];
        REG_HEIGHT: height_r <= pwdata[12:0];
        REG_PHASE:  phase_r  <= pwdata;
        default:    phase_r  <= phase_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_THEME:  prdata = {30'd0, theme_r};
      REG_WIDTH:  prdata = {19'd0, width_r};
      REG_HEIGHT: prdata = {19'd0, height_r};
      REG_PHASE:  prdata = phase_r;
      default:    prdata = '0;
    endcase
  end

  // frame size as used: zero acts as one, oversize saturates
  assign w_eff = eff_dim(width_r, 14'(MAX_WIDTH));
  assign h_eff = eff_dim(height_r, 14'(MAX_HEIGHT));

  assign full   = q_full;
  assign in_acc = push && !q_full;

  ggbg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .start_frame (in_start_frame),
    .w           (w_eff),
    .h           (h_eff),
    .item        (f_item)
  );

  ggbg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (in_acc),
    .wr_item (f_item),
    .rd      (q_pop),
    .rd_item (q_item),
    .full    (q_full),
    .nempty  (q_nempty)
  );

  ggbg_back #(
    .GRAIN_STRIDE (GRAIN_STRIDE)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_item        (q_item),
    .q_nempty      (q_nempty),
    .q_pop         (q_pop),
    .theme         (theme_r),
    .phase         (phase_r),
    .w             (w_eff),
    .h             (h_eff),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_color     (out_pixel_color),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end)
  );

  assign empty = !out_valid;

  // the last pixel of a frame always closes a row
  `GGBG_ASSERT_IMP(a_fe_is_re, out_valid && out_frame_end, out_row_end)
  // an accepted beat always lands in the queue
  `GGBG_ASSERT_NXT(a_push_lands, in_acc, q_nempty)

endmodule
